### design/thermocouple_frame_table_linearizer_assert.svh
// assertion macros shared by the linearizer
`ifndef THERMOCOUPLE_FRAME_TABLE_LINEARIZER_ASSERT_SVH
`define THERMOCOUPLE_FRAME_TABLE_LINEARIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TFL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TFL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tfl_pkg.sv
package tfl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int CHANNELS    = 4;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration register indexes
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_VOLT_STEP = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_VOLT_MIN  = CFG_AW'(1);

    localparam logic signed [31:0] VOLT_STEP_RST = 32'sd65536;
    localparam logic signed [31:0] VOLT_MIN_RST  = 32'sd0;

    // q16.16 sensitivities in mv per degree
    localparam logic signed [13:0] COLD_SENS = 14'sd2669;
    localparam logic signed [13:0] HOT_SENS  = 14'sd2705;

    localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
    localparam logic signed [47:0] SAT_LO = -48'sd2147483648;

    typedef struct packed {
        logic               mode;
        logic [9:0]         table_index;
        logic signed [31:0] table_value;
        logic [1:0]         channel;
        logic [31:0]        frame;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic               fault;
        logic signed [23:0] cold_temp;
        logic signed [31:0] hot_temp;
        logic               index_clamped;
    } t_out_item;

    // product >> 16, rounded to nearest with ties away from zero
    function automatic logic signed [47:0] q_rnd(input logic signed [63:0] p);
        logic signed [63:0] b;
        b = p + (p[63] ? 64'sd32767 : 64'sd32768);
        return b[63:16];
    endfunction

    function automatic logic signed [31:0] q_sat(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

### design/tfl_table_ram.sv
module tfl_table_ram import tfl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [TBL_AW-1:0]   i_rd_addr_lo,
    input  logic [TBL_AW-1:0]   i_rd_addr_hi,
    input  logic                i_wr_en,
    input  logic [TBL_AW-1:0]   i_wr_addr,
    input  logic signed [31:0]  i_wr_data,
    output logic signed [31:0]  o_rd_lo,
    output logic signed [31:0]  o_rd_hi
);

    logic signed [31:0] r_mem [TABLE_DEPTH];
    logic signed [31:0] r_rd_lo;
    logic signed [31:0] r_rd_hi;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_lo <= r_mem[i_rd_addr_lo];
            r_rd_hi <= r_mem[i_rd_addr_hi];
        end
    end

    assign o_rd_lo = r_rd_lo;
    assign o_rd_hi = r_rd_hi;

endmodule

### design/thermocouple_frame_table_linearizer.sv
// thermocouple frame linearizer
// input channel (i_in_valid / o_in_ready / i_in_item): mode 0 loads one q16.16
// temperature into the 1024-entry table, mode 1 processes a 32-bit converter
// frame for a channel. loads give no result; each frame gives one output item
// (o_out_valid / i_out_ready / o_out_item) with cold and hot temperature, the
// fault bit and a flag when the table position was clamped.
// config channel (i_cfg_valid / i_cfg_index / i_cfg_data) writes volt_step and
// volt_min; o_cfg_ready is always high, write only while no item is in flight.
// an eleven stage pipeline takes one item every cycle unless the receiver
// stalls; results leave from the output register. loads and frames stay in
// order: the table is written and read at the same stage, so a frame sees
// every load accepted before it. per-channel held values update at the last
// stage. when the receiver stalls, the output register holds and bubbles in
// the pipeline still fill, so o_in_ready drops only when all stages are full.
// reset empties the pipeline, clears the held temperatures and restores
// volt_step to 1.0 and volt_min to 0; table contents are kept and are
// undefined until loaded.
`include "thermocouple_frame_table_linearizer_assert.svh"

module thermocouple_frame_table_linearizer import tfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int NSTG = 10;   // index of the output stage
    localparam int GSTG = 6;    // stage fed by the table read

    typedef struct packed {
        logic               mode;
        logic [9:0]         idx;
        logic signed [31:0] val;
        logic [1:0]         ch;
        logic               fault;
        logic signed [23:0] cold;
        logic               clamped;
    } t_meta;

    localparam logic signed [32:0] TOP_POS = 33'((longint'(TABLE_DEPTH) - 1) * 65536);

    logic signed [31:0] r_volt_step;
    logic signed [31:0] r_volt_min;

    logic [NSTG:0]   r_v;
    logic [NSTG+1:0] w_rdy;
    t_meta           r_meta [NSTG];

    logic signed [28:0] r_diff0;
    logic signed [31:0] r_cv1;
    logic signed [31:0] r_hv1;
    logic signed [31:0] r_d2;
    logic signed [63:0] r_prod3;
    logic signed [31:0] r_pos4;
    logic [TBL_AW-1:0]  r_lo5;
    logic [TBL_AW-1:0]  r_hi5;
    logic [15:0]        r_frac5;
    logic [15:0]        r_frac6;
    logic signed [31:0] r_base7;
    logic signed [31:0] r_diff7;
    logic [15:0]        r_frac7;
    logic signed [31:0] r_base8;
    logic signed [63:0] r_prod8;
    logic signed [31:0] r_base9;
    logic signed [31:0] r_t9;
    t_out_item          r_out;
    logic signed [31:0] r_held [CHANNELS];

    t_meta              n_meta0;
    t_meta              n_meta5;
    t_out_item          n_out;
    logic signed [31:0] n_hot;
    logic signed [23:0] w_cold0;
    logic signed [27:0] w_hot0;
    logic signed [28:0] w_diff0;
    logic [31:0]        w_pos5;
    logic [TBL_AW-1:0]  w_lo5;
    logic signed [31:0] w_rd_lo;
    logic signed [31:0] w_rd_hi;
    logic signed [31:0] w_res;
    logic               w_ch_ok;
    logic [CH_AW-1:0]   w_held_idx;
    logic               w_wr_en;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_step <= VOLT_STEP_RST;
            r_volt_min  <= VOLT_MIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLT_STEP: r_volt_step <= i_cfg_data;
                CFG_VOLT_MIN:  r_volt_min  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // a stage loads when it is empty or its item moves on
    always_comb begin
        w_rdy[NSTG+1] = i_out_ready;
        for (int k = NSTG; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_in_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k <= NSTG; k++) begin
                if (w_rdy[k]) begin
                    // loads leave the pipe once the table write is done
                    r_v[k] <= (k == GSTG) ? (r_v[k-1] && r_meta[k-1].mode) : r_v[k-1];
                end
            end
        end
    end

    // frame decode: hot sign is field bit 13
    assign w_cold0 = $signed({i_in_item.frame[15:4], 12'd0});
    assign w_hot0  = $signed({i_in_item.frame[31:18], 14'd0});
    assign w_diff0 = 29'(w_hot0) - 29'(w_cold0);

    always_comb begin
        n_meta0         = '0;
        n_meta0.mode    = i_in_item.mode;
        n_meta0.idx     = i_in_item.table_index;
        n_meta0.val     = i_in_item.table_value;
        n_meta0.ch      = i_in_item.channel;
        n_meta0.fault   = i_in_item.frame[16];
        n_meta0.cold    = w_cold0;
        n_meta0.clamped = 1'b0;
    end

    // clamp the table position into the table
    always_comb begin
        n_meta5 = r_meta[4];
        if (r_pos4 < 0) begin
            w_pos5          = '0;
            n_meta5.clamped = 1'b1;
        end else if ($signed({r_pos4[31], r_pos4}) > TOP_POS) begin
            w_pos5          = TOP_POS[31:0];
            n_meta5.clamped = 1'b1;
        end else begin
            w_pos5          = r_pos4;
            n_meta5.clamped = 1'b0;
        end
        w_lo5 = w_pos5[TBL_AW+15:16];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_meta[0] <= n_meta0;
            r_diff0   <= w_diff0;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_meta[k] <= (k == 5) ? n_meta5 : r_meta[k-1];
            end
        end
        if (w_rdy[1]) begin
            r_cv1 <= q_sat(q_rnd(64'(r_meta[0].cold) * 64'(COLD_SENS)));
            r_hv1 <= q_sat(q_rnd(64'(r_diff0) * 64'(HOT_SENS)));
        end
        if (w_rdy[2]) begin
            r_d2 <= q_sat(48'(r_cv1) + 48'(r_hv1) - 48'(r_volt_min));
        end
        if (w_rdy[3]) begin
            r_prod3 <= 64'(r_volt_step) * 64'(r_d2);
        end
        if (w_rdy[4]) begin
            r_pos4 <= q_sat(q_rnd(r_prod3));
        end
        if (w_rdy[5]) begin
            r_lo5   <= w_lo5;
            r_hi5   <= (w_lo5 == TBL_AW'(TABLE_DEPTH - 1)) ? w_lo5 : w_lo5 + 1'b1;
            r_frac5 <= w_pos5[15:0];
        end
        if (w_rdy[6]) begin
            r_frac6 <= r_frac5;
        end
        if (w_rdy[7]) begin
            r_base7 <= w_rd_lo;
            r_diff7 <= q_sat(48'(w_rd_hi) - 48'(w_rd_lo));
            r_frac7 <= r_frac6;
        end
        if (w_rdy[8]) begin
            r_base8 <= r_base7;
            r_prod8 <= 64'(r_diff7) * 64'($signed({1'b0, r_frac7}));
        end
        if (w_rdy[9]) begin
            r_base9 <= r_base8;
            r_t9    <= q_sat(q_rnd(r_prod8));
        end
        if (w_rdy[NSTG]) begin
            r_out <= n_out;
        end
    end

    // table: loads write and frames read at the same stage, so order holds
    assign w_wr_en = w_rdy[GSTG] && r_v[GSTG-1] && !r_meta[GSTG-1].mode
                     && (32'(r_meta[GSTG-1].idx) < TABLE_DEPTH);

    tfl_table_ram u_table (
        .i_clk        (i_clk),
        .i_rd_en      (w_rdy[GSTG]),
        .i_rd_addr_lo (r_lo5),
        .i_rd_addr_hi (r_hi5),
        .i_wr_en      (w_wr_en),
        .i_wr_addr    (TBL_AW'(r_meta[GSTG-1].idx)),
        .i_wr_data    (r_meta[GSTG-1].val),
        .o_rd_lo      (w_rd_lo),
        .o_rd_hi      (w_rd_hi)
    );

    // final add, held value per channel
    assign w_res      = q_sat(48'(r_base9) + 48'(r_t9));
    assign w_ch_ok    = 32'(r_meta[9].ch) < CHANNELS;
    assign w_held_idx = CH_AW'(r_meta[9].ch);

    always_comb begin
        if (!r_meta[9].fault) begin
            n_hot = w_res;
        end else if (w_ch_ok) begin
            n_hot = r_held[w_held_idx];
        end else begin
            n_hot = '0;
        end
        n_out.out_channel   = r_meta[9].ch;
        n_out.fault         = r_meta[9].fault;
        n_out.cold_temp     = r_meta[9].cold;
        n_out.hot_temp      = n_hot;
        n_out.index_clamped = r_meta[9].clamped && !r_meta[9].fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_held[c] <= '0;
            end
        end else if (w_rdy[NSTG] && r_v[9] && !r_meta[9].fault && w_ch_ok) begin
            r_held[w_held_idx] <= w_res;
        end
    end

    assign o_out_valid = r_v[NSTG];
    assign o_out_item  = r_out;

    `TFL_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready, (&r_v) && !i_out_ready, "input stalled while a stage is free")
    `TFL_ASSERT_IMP(a_table_pair, i_clk, i_rst_n, r_v[5], (r_hi5 == r_lo5 + 1'b1) || (r_hi5 == r_lo5 && r_lo5 == TBL_AW'(TABLE_DEPTH - 1)), "bad interpolation address pair")
    `TFL_ASSERT_NEXT(a_held_update, i_clk, i_rst_n, w_rdy[NSTG] && r_v[9] && !r_meta[9].fault && w_ch_ok, r_held[$past(w_held_idx)] == o_out_item.hot_temp, "held value differs from reported")
    `TFL_ASSERT_IMP(a_fault_keeps_held, i_clk, i_rst_n, o_out_valid && o_out_item.fault && (32'(o_out_item.out_channel) < CHANNELS), o_out_item.hot_temp == r_held[CH_AW'(o_out_item.out_channel)], "fault item does not report held value")

endmodule

### tb/sv/thermocouple_frame_table_linearizer_test.sv
module thermocouple_frame_table_linearizer_test;
    import tfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    localparam int COLD_MV_PER_C = 2669;
    localparam int HOT_MV_PER_C  = 2705;
    localparam int COLD_SCALE    = 4096;
    localparam int HOT_SCALE     = 16384;
    localparam int TOP_POS       = (TABLE_DEPTH - 1) * 65536;

    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = 64'shFFFF_FFFF_8000_0000;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    // predictor state
    int volt_step = 65536;
    int volt_min = 0;
    int temp_tbl [TABLE_DEPTH];
    int held_hot [CHANNELS];

    // stimulus side view of which table entries hold a value
    bit tbl_loaded [TABLE_DEPTH];

    t_in_item  items_to_send[$];
    t_out_item expected_readings[$];

    int n_queued = 0;
    int n_err = 0;
    int n_checked = 0;
    int n_frames = 0;
    int n_loads = 0;
    int n_faults = 0;
    int n_clamped = 0;
    int n_settings = 1;
    int unsigned cycles = 0;

    int send_gap = 0;
    bit tx_calm = 1'b0;
    int tx_calm_left = 0;
    int rx_stall = 0;
    bit rx_calm = 1'b0;
    int rx_calm_left = 0;

    thermocouple_frame_table_linearizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clip32(input longint x);
        if (x > S32_MAX) return int'(S32_MAX);
        if (x < S32_MIN) return int'(S32_MIN);
        return int'(x);
    endfunction

    function automatic int sat_add(input int a, input int b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    function automatic int sat_sub(input int a, input int b);
        return clip32(longint'(a) - longint'(b));
    endfunction

    // q16.16 product, rounded half away from zero
    function automatic int q_mul(input int a, input int b);
        longint p;
        longint m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? -p : p;
        m = (m + 32768) >>> 16;
        return clip32((p < 0) ? -m : m);
    endfunction

    function automatic int cold_of(input logic [31:0] f);
        int c;
        c = $signed(f[15:4]);
        return c * COLD_SCALE;
    endfunction

    function automatic int hot_of(input logic [31:0] f);
        int h;
        h = $signed(f[31:18]);
        return h * HOT_SCALE;
    endfunction

    // junction voltage to clamped q16.16 table position
    function automatic int scaled_position(input int cold, input int hot, output bit clamped);
        int mv;
        longint pos;
        mv = sat_add(q_mul(cold, COLD_MV_PER_C), q_mul(sat_sub(hot, cold), HOT_MV_PER_C));
        pos = q_mul(volt_step, sat_sub(mv, volt_min));
        clamped = 1'b0;
        if (pos < 0) begin
            pos = 0;
            clamped = 1'b1;
        end
        if (pos > TOP_POS) begin
            pos = TOP_POS;
            clamped = 1'b1;
        end
        return int'(pos);
    endfunction

    function automatic void predict_reading(input t_in_item it);
        t_out_item r;
        int cold;
        int pos;
        int lo;
        int hi;
        int base;
        bit clamped;
        if (it.mode == MODE_LOAD) begin
            temp_tbl[it.table_index] = it.table_value;
            n_loads++;
            return;
        end
        n_frames++;
        cold = cold_of(it.frame);
        r.out_channel = it.channel;
        r.fault = it.frame[16];
        r.cold_temp = cold[23:0];
        r.index_clamped = 1'b0;
        if (it.frame[16]) begin
            r.hot_temp = held_hot[it.channel];
            n_faults++;
        end else begin
            pos = scaled_position(cold, hot_of(it.frame), clamped);
            lo = pos >>> 16;
            hi = (lo + 1 < TABLE_DEPTH) ? lo + 1 : lo;
            base = temp_tbl[TBL_AW'(lo)];
            r.hot_temp = sat_add(base, q_mul(sat_sub(temp_tbl[TBL_AW'(hi)], base),
                                             pos & 'hFFFF));
            r.index_clamped = clamped;
            held_hot[it.channel] = r.hot_temp;
            if (clamped) n_clamped++;
        end
        expected_readings.push_back(r);
    endfunction

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item random_fields();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[$bits(t_in_item)-1:0];
    endfunction

    function automatic int random_temp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? int'(S32_MAX) : int'(S32_MIN);
        if (r < 3) return $urandom();
        return int'($urandom_range(0, 2**28)) - 2**27;
    endfunction

    function automatic logic [31:0] make_frame(input logic [13:0] hot, input logic fault,
                                               input logic [11:0] cold);
        return {hot, 1'b0, fault, cold, 4'h0};
    endfunction

    task automatic queue_load(input int idx, input int value);
        t_in_item it;
        it = random_fields();
        it.mode = MODE_LOAD;
        it.table_index = 10'(idx);
        it.table_value = value;
        tbl_loaded[TBL_AW'(idx)] = 1'b1;
        items_to_send.push_back(it);
        n_queued++;
    endtask

    // a frame never reads a table entry that has not been loaded
    task automatic queue_frame(input int ch, input logic [31:0] f);
        t_in_item it;
        bit cl;
        int lo;
        if (!f[16]) begin
            lo = scaled_position(cold_of(f), hot_of(f), cl) >>> 16;
            if (!tbl_loaded[TBL_AW'(lo)]) queue_load(lo, random_temp());
            if (lo + 1 < TABLE_DEPTH && !tbl_loaded[TBL_AW'(lo + 1)])
                queue_load(lo + 1, random_temp());
        end
        it = random_fields();
        it.mode = MODE_FRAME;
        it.channel = 2'(ch);
        it.frame = f;
        items_to_send.push_back(it);
        n_queued++;
    endtask

    task automatic queue_random(input int n);
        int target;
        int roll;
        logic [31:0] f;
        target = n_queued + n;
        while (n_queued < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                queue_load($urandom_range(0, TABLE_DEPTH - 1), random_temp());
            end else begin
                f = $urandom();
                f[16] = ($urandom_range(0, 3) == 0);
                // keep a share of frames near room temperature so steep scales stay in range
                if (roll < 40) f[31:18] = 14'($urandom_range(0, 1200));
                queue_frame($urandom_range(0, CHANNELS - 1), f);
            end
        end
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
        // loads give no result, let them leave the pipeline too
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_VOLT_STEP) begin
            volt_step = val;
        end else begin
            volt_min = val;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (n_err < 40) $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        n_err++;
    endtask

    // input side
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) predict_reading(in_item);
            if (tx_calm_left == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                tx_calm_left = $urandom_range(50, 400);
            end else begin
                tx_calm_left--;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    in_item <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = idle_len(tx_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_calm_left == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
                rx_calm_left = $urandom_range(50, 400);
            end else begin
                rx_calm_left--;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                rx_stall = idle_len(rx_calm);
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("item with nothing expected, hot_temp", out_item.hot_temp, 0);
            end else begin
                want = expected_readings.pop_front();
                n_checked++;
                if (out_item.out_channel !== want.out_channel)
                    report_mismatch("out_channel", out_item.out_channel, want.out_channel);
                if (out_item.fault !== want.fault)
                    report_mismatch("fault", out_item.fault, want.fault);
                if (out_item.cold_temp !== want.cold_temp)
                    report_mismatch("cold_temp", out_item.cold_temp, want.cold_temp);
                if (out_item.hot_temp !== want.hot_temp)
                    report_mismatch("hot_temp", out_item.hot_temp, want.hot_temp);
                if (out_item.index_clamped !== want.index_clamped)
                    report_mismatch("index_clamped", out_item.index_clamped, want.index_clamped);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("thermocouple_frame_table_linearizer_test: errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] steps [NUM_PHASES];
        logic [31:0] mins [NUM_PHASES];
        int counts [NUM_PHASES];
        steps  = '{32'd786432, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFF4_0000,
                   32'd0, 32'd1, 32'd65536, 32'd1585209};
        mins   = '{32'hFFFD_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5570560,
                   32'd0, 32'h8000_0000, 32'd0, 32'hFFD8_0000};
        counts = '{200, 50, 50, 150, 50, 50, 150, 200};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset scale: one entry per millivolt from zero
        queue_load(0, int'(S32_MAX));
        queue_load(1, int'(S32_MIN));
        queue_load(TABLE_DEPTH - 2, int'(S32_MIN));
        queue_load(TABLE_DEPTH - 1, 32'sh0123_4567);
        queue_frame(0, make_frame(14'h0001, 1'b0, 12'h000));
        queue_frame(1, make_frame(14'h2000, 1'b0, 12'h800));
        queue_frame(2, make_frame(14'h1FFF, 1'b0, 12'h7FF));
        queue_frame(2, make_frame(14'h1FFF, 1'b1, 12'h7FF));
        queue_frame(3, make_frame(14'h0000, 1'b1, 12'h000));
        // bit 12 of the hot field alone is not a sign
        queue_frame(0, make_frame(14'h1000, 1'b0, 12'h010));
        queue_frame(1, make_frame(14'h3000, 1'b0, 12'hFF0));
        queue_frame(1, 32'hFFFF_FFFF);
        queue_frame(3, 32'hFFFE_FFFF);
        queue_frame(0, 32'h0000_0000);
        wait_drained();

        // steep scale pushes hot frames past the last entry
        write_reg(CFG_VOLT_STEP, 32'd1048576);
        write_reg(CFG_VOLT_MIN, 32'd0);
        n_settings++;
        queue_frame(2, make_frame(14'h1FFF, 1'b0, 12'h000));
        queue_frame(3, make_frame(14'h0F00, 1'b0, 12'h190));
        queue_frame(2, make_frame(14'h0000, 1'b1, 12'h000));

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(CFG_VOLT_STEP, steps[p]);
            write_reg(CFG_VOLT_MIN, mins[p]);
            n_settings++;
            queue_random(counts[p]);
        end

        wait_drained();
        $display("checked %0d readings: %0d frames (%0d faulted, %0d clamped), %0d table loads",
                 n_checked, n_frames, n_faults, n_clamped, n_loads);
        $display("across %0d scale and offset settings, with random gaps and output stalls",
                 n_settings);
        if (n_err == 0) begin
            $display("thermocouple_frame_table_linearizer_test: clean");
        end else begin
            $display("thermocouple_frame_table_linearizer_test: errors");
        end
        $finish;
    end

endmodule
